// ----- sv/d8_steepest_descent_receiver_defines.svh -----
// assertion macros for the steepest descent receiver
`ifndef D8_STEEPEST_DESCENT_RECEIVER_DEFINES_SVH
`define D8_STEEPEST_DESCENT_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
`define D8SD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define D8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define D8SD_ASSERT_NOW(lbl, ante, cons, msg)
`define D8SD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/d8sd_pkg.sv -----
package d8sd_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WID_W     = ADDR_W + 1;
    localparam int ELEV_W    = 32;
    localparam int LINE_W    = 2 * ELEV_W;
    localparam int DROP_W    = ELEV_W + 1;
    localparam int SLOPE_W   = DROP_W + 17;
    localparam int ORTHO_SHIFT = 16;

    localparam logic signed [16:0] DIAG_RECIP_Q16 = 17'sd46341;

    localparam logic [3:0] DIR_NONE = 4'd8;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    // neighbour order W, NW, N, NE, E, SE, S, SW as window row and column
    localparam logic [1:0] NBR_ROW [8] = '{2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] NBR_COL [8] = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0};

    typedef logic signed [ELEV_W-1:0] elev_t;

    typedef struct packed {
        logic              emit;
        logic [ADDR_W-1:0] addr;
        logic [11:0]       cell_x;
        logic [15:0]       cell_y;
    } pos_t;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic [3:0]                dir;
    } cand_t;

    // earlier candidate keeps a tie
    function automatic cand_t pick(cand_t a, cand_t b);
        return (b.slope > a.slope) ? b : a;
    endfunction

endpackage

// ----- sv/d8_steepest_descent_receiver.sv -----
// D8 flow direction for a raster elevation stream. One sample is taken per clock
// cycle while the output is not stalled. Both line buffers share one 4096 x 64
// memory with one read and one write port, read at the incoming column and
// written back when the sample leaves the window stage, so the memory port sets
// the rate of one item a cycle. The pipeline only halts while a result sits in
// the output register and is not taken. The user must write frame_width and
// frame_height only while idle; the block itself does not enforce this.
`include "d8_steepest_descent_receiver_defines.svh"

module d8_steepest_descent_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_elevation,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_cell_x,
    output logic [15:0] m_cell_y,
    output logic [3:0]  m_direction,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import d8sd_pkg::*;

    logic              advance, accept;
    pos_t              pos;

    logic              s1_valid_reg;
    elev_t             s1_sample_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_emit_reg;
    logic [11:0]       s1_cell_x_reg;
    logic [15:0]       s1_cell_y_reg;
    logic              s1_fwd_reg;
    logic [LINE_W-1:0] s1_fwd_data_reg;
    logic              fwd_next;

    logic              ram_we;
    logic [LINE_W-1:0] ram_wdata, ram_rdata, line_sel;
    elev_t             line0, line1;
    elev_t             col [3];
    elev_t             win_reg [3][2];
    elev_t             window [3][3];

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    d8sd_pos u_pos (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .frame_start (s_frame_start),
        .pos         (pos)
    );

    // upper half: row two above, lower half: row above
    d8sd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s1_addr_reg),
        .wr_data (ram_wdata),
        .rd_en   (accept),
        .rd_addr (pos.addr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        line_sel  = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
        line0     = $signed(line_sel[ELEV_W-1:0]);
        line1     = $signed(line_sel[LINE_W-1:ELEV_W]);
        ram_wdata = {line0, s1_sample_reg};
        ram_we    = s1_valid_reg && advance;
        fwd_next  = s1_valid_reg && (s1_addr_reg == pos.addr);
        col[0]    = line1;
        col[1]    = line0;
        col[2]    = s1_sample_reg;
        for (int r = 0; r < 3; r++) begin
            window[r][0] = win_reg[r][0];
            window[r][1] = win_reg[r][1];
            window[r][2] = col[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg   <= s_elevation;
            s1_addr_reg     <= pos.addr;
            s1_emit_reg     <= pos.emit;
            s1_cell_x_reg   <= pos.cell_x;
            s1_cell_y_reg   <= pos.cell_y;
            s1_fwd_reg      <= fwd_next;
            s1_fwd_data_reg <= ram_wdata;
        end
        if (ram_we) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= col[r];
            end
        end
    end

    d8sd_dir u_dir (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_valid    (s1_valid_reg && s1_emit_reg),
        .win         (window),
        .in_cell_x   (s1_cell_x_reg),
        .in_cell_y   (s1_cell_y_reg),
        .m_valid     (m_valid),
        .m_cell_x    (m_cell_x),
        .m_cell_y    (m_cell_y),
        .m_direction (m_direction)
    );

    `D8SD_ASSERT_NEXT(a_fwd_flag, accept && s1_valid_reg && (s1_addr_reg == pos.addr), s1_fwd_reg, "same column read not forwarded")
    `D8SD_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_addr_reg), "window stage lost its item")
    `D8SD_ASSERT_NOW(a_dir_code, m_valid, m_direction <= DIR_NONE, "direction code out of range")
    `D8SD_ASSERT_NOW(a_cell_inside, m_valid, (m_cell_x >= 12'd2) && (m_cell_y >= 16'd2), "border cell emitted")

endmodule

// ----- sv/d8sd_ram.sv -----
module d8sd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/d8sd_pos.sv -----
module d8sd_pos (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [0:0]     cfg_index,
    input  logic [15:0]    cfg_wdata,
    input  logic           accept,
    input  logic           frame_start,
    output d8sd_pkg::pos_t pos
);
    import d8sd_pkg::*;

    localparam int CMP_W = (WID_W > 13) ? WID_W : 13;

    logic [12:0]       frame_width_reg;
    logic [15:0]       frame_height_reg;
    logic [ADDR_W-1:0] col_reg, col_next, col_cur, x;
    logic [15:0]       row_reg, row_next, row_cur;
    logic [CMP_W-1:0]  fw_ext, w_eff, x_ext;
    logic [16:0]       h_eff, y_ext;
    logic              last_col, emit;

    always_comb begin
        fw_ext = CMP_W'(frame_width_reg);
        if (fw_ext == '0) begin
            w_eff = CMP_W'(1);
        end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        h_eff = (frame_height_reg == '0) ? 17'd1 : {1'b0, frame_height_reg};

        col_cur = frame_start ? '0 : col_reg;
        row_cur = frame_start ? '0 : row_reg;

        x_ext = CMP_W'(col_cur);
        if (x_ext >= w_eff) begin
            x_ext = w_eff - CMP_W'(1);
        end
        x     = x_ext[ADDR_W-1:0];
        y_ext = {1'b0, row_cur};

        // interior: two-cell border dropped, emitted one column and row late
        emit = (w_eff >= CMP_W'(5)) && (h_eff >= 17'd5)
            && (x_ext >= CMP_W'(3)) && ((x_ext + CMP_W'(2)) <= w_eff)
            && (y_ext >= 17'd3) && ((y_ext + 17'd2) <= h_eff);

        last_col = (x_ext + CMP_W'(1)) >= w_eff;
        if (last_col) begin
            col_next = '0;
            row_next = ((y_ext + 17'd1) >= h_eff) ? '0 : row_cur + 16'd1;
        end else begin
            col_next = x + ADDR_W'(1);
            row_next = row_cur;
        end

        pos.emit   = emit;
        pos.addr   = x;
        pos.cell_x = 12'(x_ext - CMP_W'(1));
        pos.cell_y = row_cur - 16'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 13'd1024;
            frame_height_reg <= 16'd1024;
            col_reg          <= '0;
            row_reg          <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[12:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                    default:          frame_height_reg <= frame_height_reg;
                endcase
            end
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

// ----- sv/d8sd_dir.sv -----
module d8sd_dir (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  d8sd_pkg::elev_t win [3][3],
    input  logic [11:0]     in_cell_x,
    input  logic [15:0]     in_cell_y,
    output logic            m_valid,
    output logic [11:0]     m_cell_x,
    output logic [15:0]     m_cell_y,
    output logic [3:0]      m_direction
);
    import d8sd_pkg::*;

    logic signed [DROP_W-1:0] drop_next [8];
    logic signed [DROP_W-1:0] s2_drop_reg [8];
    logic                     s2_valid_reg;
    logic [11:0]              s2_cell_x_reg;
    logic [15:0]              s2_cell_y_reg;

    cand_t       s3_cand_next [8];
    cand_t       s3_cand_reg [8];
    logic        s3_valid_reg;
    logic [11:0] s3_cell_x_reg;
    logic [15:0] s3_cell_y_reg;

    cand_t       s4_cand_next [4];
    cand_t       s4_cand_reg [4];
    logic        s4_valid_reg;
    logic [11:0] s4_cell_x_reg;
    logic [15:0] s4_cell_y_reg;

    cand_t       best;
    logic [3:0]  dir_next;
    logic        m_valid_reg;
    logic [11:0] m_cell_x_reg;
    logic [15:0] m_cell_y_reg;
    logic [3:0]  m_direction_reg;

    always_comb begin
        for (int n = 0; n < 8; n++) begin
            drop_next[n] = DROP_W'(win[1][1]) - DROP_W'(win[NBR_ROW[n]][NBR_COL[n]]);
        end
    end

    // diagonals scaled by 1/sqrt2 in q16, orthogonals by one
    always_comb begin
        for (int n = 0; n < 8; n++) begin
            if (n[0]) begin
                s3_cand_next[n].slope = SLOPE_W'(s2_drop_reg[n]) * SLOPE_W'(DIAG_RECIP_Q16);
            end else begin
                s3_cand_next[n].slope = SLOPE_W'(s2_drop_reg[n]) <<< ORTHO_SHIFT;
            end
            s3_cand_next[n].dir = 4'(n);
        end
    end

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            s4_cand_next[n] = pick(s3_cand_reg[2*n], s3_cand_reg[2*n+1]);
        end
        best     = pick(pick(s4_cand_reg[0], s4_cand_reg[1]),
                        pick(s4_cand_reg[2], s4_cand_reg[3]));
        dir_next = (best.slope > 0) ? best.dir : DIR_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= in_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_drop_reg     <= drop_next;
            s2_cell_x_reg   <= in_cell_x;
            s2_cell_y_reg   <= in_cell_y;
            s3_cand_reg     <= s3_cand_next;
            s3_cell_x_reg   <= s2_cell_x_reg;
            s3_cell_y_reg   <= s2_cell_y_reg;
            s4_cand_reg     <= s4_cand_next;
            s4_cell_x_reg   <= s3_cell_x_reg;
            s4_cell_y_reg   <= s3_cell_y_reg;
            m_cell_x_reg    <= s4_cell_x_reg;
            m_cell_y_reg    <= s4_cell_y_reg;
            m_direction_reg <= dir_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_cell_x    = m_cell_x_reg;
    assign m_cell_y    = m_cell_y_reg;
    assign m_direction = m_direction_reg;

endmodule

// ----- tb/sv/d8_steepest_descent_receiver_tb.sv -----
module d8_steepest_descent_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import d8sd_pkg::*;

    typedef struct packed {
        logic [11:0] x;
        logic [15:0] y;
        logic [3:0]  dir;
    } cell_t;

    typedef enum {
        RELIEF_NOISE,
        RELIEF_STEPS,
        RELIEF_TILT,
        RELIEF_EXTREME,
        RELIEF_TIES
    } relief_e;

    // steepest descent tracker: mirrors window, line stores and position
    class flow_board;
        int unsigned width_reg = 1024;
        int unsigned height_reg = 1024;
        bit [31:0]   line_up [MAX_WIDTH];
        bit [31:0]   line_up2 [MAX_WIDTH];
        bit [31:0]   win [3][2];
        int unsigned col_pos;
        int unsigned row_pos;
        cell_t       pending [$];
        int unsigned faults;

        function void write_reg(logic [0:0] idx, logic [15:0] value);
            if (idx == REG_FRAME_WIDTH) begin
                width_reg = value[12:0];
            end else begin
                height_reg = value;
            end
        endfunction

        function void take_sample(logic [31:0] elev, logic fs);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned y;
            bit [31:0]   column [3];
            longint      g [3][3];
            longint      best;
            longint      drop;
            longint      slope;
            logic [3:0]  dir;
            cell_t       hit;
            w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
            if (w == 0)
                w = 1;
            h = (height_reg == 0) ? 1 : height_reg;
            if (fs) begin
                col_pos = 0;
                row_pos = 0;
            end
            x = (col_pos >= w) ? w - 1 : col_pos;
            y = row_pos;
            column[0] = line_up2[x];
            column[1] = line_up[x];
            column[2] = elev;
            if (w >= 5 && h >= 5 && x >= 3 && x <= w - 2 && y >= 3 && y <= h - 2) begin
                for (int r = 0; r < 3; r++) begin
                    g[r][0] = $signed(win[r][0]);
                    g[r][1] = $signed(win[r][1]);
                    g[r][2] = $signed(column[r]);
                end
                best = 0;
                dir = DIR_NONE;
                for (int n = 0; n < 8; n++) begin
                    drop = g[1][1] - g[NBR_ROW[n]][NBR_COL[n]];
                    slope = (n & 1) ? drop * longint'(DIAG_RECIP_Q16) : drop <<< ORTHO_SHIFT;
                    if (slope > best) begin
                        best = slope;
                        dir = 4'(n);
                    end
                end
                hit.x = 12'(x - 1);
                hit.y = 16'(y - 1);
                hit.dir = dir;
                pending = {pending, hit};
            end
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = column[r];
            end
            line_up2[x] = line_up[x];
            line_up[x] = elev;
            if (x + 1 >= w) begin
                col_pos = 0;
                row_pos = (y + 1 >= h) ? 0 : ((y + 1) & 32'hFFFF);
            end else begin
                col_pos = x + 1;
                row_pos = y;
            end
        endfunction

        function void check_cell(logic [11:0] x, logic [15:0] y, logic [3:0] dir);
            cell_t want;
            if (pending.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: unexpected cell x=%0d y=%0d dir=%0d", x, y, dir);
            end else begin
                want = pending.pop_front();
                if (want.x !== x || want.y !== y || want.dir !== dir) begin
                    faults++;
                    if (faults <= 10)
                        $display("mismatch: expected x=%0d y=%0d dir=%0d, got x=%0d y=%0d dir=%0d",
                                 want.x, want.y, want.dir, x, y, dir);
                end
            end
        endfunction
    endclass

    localparam logic [31:0] PEAK_GRID [25] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
        32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
        32'h5555_5555, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hAAAA_AAAA,
        32'hFFFF_0000, 32'h0000_FFFF, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0000
    };

    // south drop of 46341 and south-west drop of 65536 give equal slopes
    localparam logic [31:0] TIE_GRID [25] = '{
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'hFFFF_0000, 32'hFFFF_4AFB, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0
    };

    localparam logic [31:0] EXTREMES [4] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
    };

    localparam logic [31:0] TIE_STEPS [4] = '{32'd0, 32'd46341, 32'd65536, 32'd92682};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_elevation = '0;
    logic        s_frame_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_cell_x;
    logic [15:0] m_cell_y;
    logic [3:0]  m_direction;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = REG_FRAME_WIDTH;
    logic [15:0] cfg_wdata = '0;

    flow_board   board;
    int unsigned burst_left;
    bit          tx_gaps;
    bit          rx_stalls;
    bit          hold_ask;
    bit          rx_state;
    int unsigned rx_run;
    logic [31:0] base;
    int          tilt_x;
    int          tilt_y;
    int unsigned random_items;

    d8_steepest_descent_receiver uut (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.take_sample(s_elevation, s_frame_start);
            if (m_valid && m_ready)
                board.check_cell(m_cell_x, m_cell_y, m_direction);
        end
    end

    // result side back-pressure
    always begin
        @(negedge aclk);
        if (hold_ask) begin
            hold_ask = 1'b0;
            m_ready <= 1'b0;
            repeat (400) @(negedge aclk);
        end
        if (rx_run == 0) begin
            rx_state = ~rx_state;
            rx_run = rx_state ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end
        rx_run--;
        m_ready <= rx_stalls ? rx_state : 1'b1;
    end

    function automatic logic [31:0] terrain(relief_e relief, int unsigned x, int unsigned y);
        case (relief)
            RELIEF_NOISE:   return $urandom();
            RELIEF_STEPS:   return base + ($urandom_range(0, 3) << 16);
            RELIEF_TILT:    return base + x * tilt_x + y * tilt_y + $urandom_range(0, 3);
            RELIEF_EXTREME: return ($urandom_range(0, 4) == 0) ? $urandom()
                                                               : EXTREMES[$urandom_range(0, 3)];
            default:        return base + TIE_STEPS[$urandom_range(0, 3)];
        endcase
    endfunction

    task automatic push_sample(input logic [31:0] elev, input logic fs);
        int unsigned gap;
        if (burst_left == 0) begin
            if (tx_gaps) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_elevation <= elev;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic set_geometry(input logic [15:0] w, input logic [15:0] h);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        board.write_reg(REG_FRAME_WIDTH, w);
        board.write_reg(REG_FRAME_HEIGHT, h);
    endtask

    task automatic drain_cells();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic send_frame(input int unsigned w, input int unsigned h, input relief_e relief,
                              input logic fs, input int unsigned count, input bit noisy,
                              output bit broke);
        bit restart;
        broke = (count < w * h);
        base = $urandom();
        tilt_x = int'($urandom_range(0, 131072)) - 65536;
        tilt_y = int'($urandom_range(0, 131072)) - 65536;
        for (int unsigned i = 0; i < count; i++) begin
            restart = noisy && (i > 0) && ($urandom_range(0, 63) == 0);
            if (restart)
                broke = 1'b1;
            push_sample(terrain(relief, i % w, i / w), (i == 0) ? fs : restart);
        end
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        int unsigned count;
        bit          need_fs;
        bit          broke;
        bit          first;
        board = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // full-range drops, equal slopes, wrap with no frame start, restart mid-grid
        set_geometry(16'd5, 16'd5);
        for (int i = 0; i < 25; i++)
            push_sample(PEAK_GRID[i], i == 0);
        for (int i = 0; i < 25; i++)
            push_sample(TIE_GRID[i], 1'b0);
        for (int i = 0; i < 7; i++)
            push_sample(TIE_GRID[i], i == 0);
        for (int i = 0; i < 25; i++)
            push_sample(PEAK_GRID[i], i == 0);

        // oversized width register
        drain_cells();
        rx_stalls = 1'b1;
        set_geometry(16'hFFFF, 16'd5);
        send_frame(MAX_WIDTH, 5, relief_e'($urandom_range(0, 4)), 1'b1, 60, 1'b0,
                   broke);

        drain_cells();
        set_geometry(16'd5, 16'hFFFF);
        send_frame(5, 65535, RELIEF_NOISE, 1'b1, 50, 1'b0, broke);

        // grids too narrow or too short for interior cells
        drain_cells();
        set_geometry(16'd4, 16'd9);
        send_frame(4, 9, RELIEF_NOISE, 1'b1, 40, 1'b0, broke);
        drain_cells();
        set_geometry(16'd0, 16'd0);
        send_frame(1, 1, RELIEF_NOISE, 1'b1, 12, 1'b0, broke);
        drain_cells();
        set_geometry(16'd9, 16'd4);
        send_frame(9, 4, RELIEF_NOISE, 1'b1, 45, 1'b0, broke);

        first = 1'b1;
        random_items = 0;
        while (random_items < 600) begin
            if (first) begin
                w = 12;
                h = 12;
            end else begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(5, 12);
                h = $urandom_range(5, 9);
            end
            drain_cells();
            set_geometry(16'(w), 16'(h));
            tx_gaps = first ? 1'b0 : ($urandom_range(0, 2) != 0);
            rx_stalls = first ? 1'b0 : ($urandom_range(0, 2) != 0);
            hold_ask = first;
            frames = first ? 3 : $urandom_range(1, 3);
            need_fs = 1'b1;
            for (int f = 0; f < frames; f++) begin
                count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h - 1) : w * h;
                send_frame(w, h, relief_e'($urandom_range(0, 4)),
                           need_fs || ($urandom_range(0, 1) == 1), count,
                           $urandom_range(0, 9) == 0, broke);
                need_fs = broke;
                random_items += count;
            end
            first = 1'b0;
        end

        s_valid <= 1'b0;
        for (int k = 0; k < 100000 && board.pending.size() != 0; k++)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.pending.size() != 0)
            $display("missing %0d cells at end of run", board.pending.size());
        board.faults += board.pending.size();
        if (board.faults == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

endmodule
